// File: src/tpvb_pkg.sv
// Package: request/result types, codes and controller/datapath interface structs.
`timescale 1ns / 1ps
package tpvb_pkg;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_AID = 2'd1,
    STATUS_NO_ROOM = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] aid;
    logic        has_traffic;
    logic [7:0]  buffer_len;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  pvb_offset;
    logic [7:0]  bitmap_length;
    logic        group_traffic;
    logic        dozing_clients;
    logic [63:0] data_word;
    logic [3:0]  data_bytes;
    logic        last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    set_wr;
    logic    clear;
    logic    scan_init;
    logic    scan_rd;
    logic    stream_init;
    logic    stream_rd;
    logic    emit_ack;
    status_e ack_status;
    logic    emit_small;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic aid_bad;
    logic scan_last;
    logic too_small;
    logic stream_last;
  } stat_t;

endpackage

// File: src/tpvb_ctrl.sv
// Controller state machine sequencing set, clear and read requests.
`timescale 1ns / 1ps
module tpvb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output tpvb_pkg::cmd_t cmd_o,
  input  tpvb_pkg::stat_t stat_i
);
  import tpvb_pkg::*;

  localparam logic [2:0] StIdle        = 3'd0;
  localparam logic [2:0] StDecode      = 3'd1;
  localparam logic [2:0] StSetWr       = 3'd2;
  localparam logic [2:0] StScan        = 3'd3;
  localparam logic [2:0] StScanDrain   = 3'd4;
  localparam logic [2:0] StCalc        = 3'd5;
  localparam logic [2:0] StStream      = 3'd6;
  localparam logic [2:0] StStreamDrain = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.ack_status = STATUS_OK;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecode;
        end
      end
      StDecode: begin
        unique case (stat_i.op)
          OP_SET: begin
            if (stat_i.aid_bad) begin
              cmd_o.emit_ack   = 1'b1;
              cmd_o.ack_status = STATUS_BAD_AID;
              state_d          = StIdle;
            end else begin
              state_d = StSetWr;
            end
          end
          OP_CLEAR: begin
            cmd_o.clear    = 1'b1;
            cmd_o.emit_ack = 1'b1;
            state_d        = StIdle;
          end
          OP_READ: begin
            cmd_o.scan_init = 1'b1;
            state_d         = StScan;
          end
          default: begin
            cmd_o.emit_ack = 1'b1;
            state_d        = StIdle;
          end
        endcase
      end
      StSetWr: begin
        cmd_o.set_wr   = 1'b1;
        cmd_o.emit_ack = 1'b1;
        state_d        = StIdle;
      end
      StScan: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) state_d = StScanDrain;
      end
      StScanDrain: begin
        state_d = StCalc;
      end
      StCalc: begin
        if (stat_i.too_small) begin
          cmd_o.emit_small = 1'b1;
          state_d          = StIdle;
        end else begin
          cmd_o.stream_init = 1'b1;
          state_d           = StStream;
        end
      end
      StStream: begin
        cmd_o.stream_rd = 1'b1;
        if (stat_i.stream_last) state_d = StStreamDrain;
      end
      StStreamDrain: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// File: src/tpvb_datapath.sv
// Datapath: bitmap memory with valid bits, range scan and byte packing.
`timescale 1ns / 1ps
module tpvb_datapath #(
  parameter int unsigned AID_COUNT = 2008
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tpvb_pkg::req_t  req_i,
  input  tpvb_pkg::cmd_t  cmd_i,
  output tpvb_pkg::stat_t stat_o,
  output tpvb_pkg::res_t  res_o,
  output logic            res_valid_o
);
  import tpvb_pkg::*;

  localparam int unsigned MapBytes = (AID_COUNT + 7) / 8;
  localparam int unsigned AddrW    = $clog2(MapBytes);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MapBytes - 1);

  req_t req_q;

  logic [7:0]       mem [MapBytes];
  logic [MapBytes-1:0] valid_q;
  logic [7:0]       rdata_q;
  logic             rvld_q;
  logic [AddrW-1:0] raddr;
  logic [AddrW-1:0] aid_idx;

  logic [AddrW-1:0] cnt_q;
  logic             pv_q;
  logic             stream_mode_q;
  logic [AddrW-1:0] paddr_q;

  logic             found_q;
  logic             grp_q;
  logic [AddrW-1:0] first_q, last_q;

  logic [63:0] word_q;
  logic [2:0]  nb_q;
  logic [7:0]  done_q;

  logic [AddrW-1:0] n1, n2;
  logic [7:0]       len;
  logic [6:0]       offset;
  logic [7:0]       rbyte, sbyte, wbyte;
  logic [63:0]      word_nxt;
  logic             pack_emit, pack_last;

  res_t res_q;
  logic res_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
  end

  assign aid_idx = AddrW'(req_q.aid >> 3);
  assign raddr   = (cmd_i.scan_rd || cmd_i.stream_rd) ? cnt_q : aid_idx;
  assign rbyte   = rvld_q ? rdata_q : 8'h00;

  // read-modify-write of the addressed byte for a set request
  always_comb begin
    wbyte = rbyte;
    wbyte[req_q.aid[2:0]] = req_q.has_traffic;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_wr) mem[aid_idx] <= wbyte;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      rvld_q <= valid_q[raddr];
      if (cmd_i.clear) begin
        valid_q <= '0;
      end else if (cmd_i.set_wr) begin
        valid_q[aid_idx] <= 1'b1;
      end
    end
  end

  // scan of the map for first and last byte with a station bit set
  assign sbyte = (paddr_q == '0) ? (rbyte & 8'hFE) : rbyte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      pv_q          <= 1'b0;
      stream_mode_q <= 1'b0;
      paddr_q       <= '0;
      found_q       <= 1'b0;
      grp_q         <= 1'b0;
      first_q       <= '0;
      last_q        <= '0;
    end else begin
      pv_q    <= cmd_i.scan_rd || cmd_i.stream_rd;
      paddr_q <= cnt_q;
      if (cmd_i.scan_init) begin
        cnt_q         <= '0;
        found_q       <= 1'b0;
        grp_q         <= 1'b0;
        stream_mode_q <= 1'b0;
      end else if (cmd_i.stream_init) begin
        cnt_q         <= n1;
        stream_mode_q <= 1'b1;
      end else if (cmd_i.scan_rd || cmd_i.stream_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (pv_q && !stream_mode_q) begin
        if (paddr_q == '0) grp_q <= rbyte[0];
        if (sbyte != 8'h00) begin
          if (!found_q) first_q <= paddr_q;
          last_q  <= paddr_q;
          found_q <= 1'b1;
        end
      end
    end
  end

  assign n1     = found_q ? (first_q & ~AddrW'(1)) : '0;
  assign n2     = found_q ? last_q : '0;
  assign len    = 8'(n2) - 8'(n1) + 8'd1;
  assign offset = 7'(8'(n1) >> 1);

  assign stat_o.op          = op_e'(req_q.op);
  assign stat_o.aid_bad     = (req_q.aid >= 12'(AID_COUNT));
  assign stat_o.scan_last   = (cnt_q == LastAddr);
  assign stat_o.too_small   = (req_q.buffer_len < len);
  assign stat_o.stream_last = (cnt_q == n2);

  // pack streamed bytes, eight to a result
  always_comb begin
    word_nxt = word_q;
    word_nxt[{nb_q, 3'b000} +: 8] = rbyte;
  end
  assign pack_last = (done_q + 8'd1 == len);
  assign pack_emit = pv_q && stream_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_q   <= '0;
      done_q <= '0;
    end else if (cmd_i.stream_init) begin
      nb_q   <= '0;
      done_q <= '0;
    end else if (pack_emit) begin
      done_q <= done_q + 8'd1;
      nb_q   <= (pack_last || nb_q == 3'd7) ? 3'd0 : nb_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.stream_init) begin
      word_q <= '0;
    end else if (pack_emit) begin
      word_q <= (pack_last || nb_q == 3'd7) ? 64'd0 : word_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit_ack || cmd_i.emit_small ||
                     (pack_emit && (pack_last || nb_q == 3'd7));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ack) begin
      res_q        <= '0;
      res_q.status <= cmd_i.ack_status;
      res_q.last   <= 1'b1;
    end else if (cmd_i.emit_small) begin
      res_q                <= '0;
      res_q.status         <= STATUS_NO_ROOM;
      res_q.bitmap_length  <= len;
      res_q.group_traffic  <= grp_q;
      res_q.dozing_clients <= found_q;
      res_q.last           <= 1'b1;
    end else if (pack_emit) begin
      res_q.status         <= STATUS_OK;
      res_q.pvb_offset     <= offset;
      res_q.bitmap_length  <= len;
      res_q.group_traffic  <= grp_q;
      res_q.dozing_clients <= found_q;
      res_q.data_word      <= word_nxt;
      res_q.data_bytes     <= {1'b0, nb_q} + 4'd1;
      res_q.last           <= pack_last;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

endmodule

// File: src/tim_partial_virtual_bitmap.sv
// Top level: traffic indication map with partial virtual bitmap readout.
`timescale 1ns / 1ps
// Usage:
//   A request (req_i) is taken on a rising edge with start_i high and busy_o low.
//   Each result appears on res_o for exactly one cycle with res_valid_o high;
//   the receiver must take it then, it cannot stall the block.
//   Clear request: the whole map is emptied at once through per-byte valid bits.
//   Read request: the map of MapBytes = ceil(AID_COUNT/8) bytes (251 at the
//   default) is scanned one byte per cycle through the single memory read port,
//   then bytes N1..N2 are read one per cycle and packed eight per result.
//   When the buffer is too small, a single result is returned instead.
//   busy_o stays high until the final result of a request is issued; last marks it.
//   Reset empties the map; the block is ready in the first cycle after reset.
module tim_partial_virtual_bitmap #(
  parameter int unsigned AID_COUNT = 2008
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  tpvb_pkg::req_t req_i,
  output tpvb_pkg::res_t res_o,
  output logic           res_valid_o
);
  import tpvb_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  tpvb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  tpvb_datapath #(
    .AID_COUNT (AID_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

// File: verif/testbench.sv
// Testbench for the TIM partial virtual bitmap: directed and random requests vs. a local map model.
`timescale 1ns / 1ps
module testbench;
  import tpvb_pkg::*;

  localparam int AidCount  = 2008;
  localparam int MapBytes  = 251;
  localparam int MaxReport = 10;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic res_valid_o;
  req_t req_i;
  res_t res_o;

  // local copy of the traffic map and the results still owed by the block
  logic [7:0] tim_bits [MapBytes];
  res_t       pending_results [$];

  int mismatch_count;
  int results_seen;
  int reads_sent;
  int reads_no_room;
  int bad_aids;
  int idle_pct;

  tim_partial_virtual_bitmap #(
    .AID_COUNT(AidCount)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .res_o      (res_o),
    .res_valid_o(res_valid_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic req_t make_request(op_e op, int aid, bit has, int buf_len);
    req_t r;
    r.op          = op;
    r.aid         = aid[11:0];
    r.has_traffic = has;
    r.buffer_len  = buf_len[7:0];
    return r;
  endfunction

  // N1/N2 byte span of the set bits above AID 0
  function automatic void find_span(output int n1, output int n2, output bit doz);
    int first_aid;
    int last_aid;
    first_aid = 0;
    last_aid  = 0;
    doz       = 1'b0;
    for (int n = 1; n < AidCount; n++) begin
      if (tim_bits[n >> 3][n & 7]) begin
        if (!doz) first_aid = n;
        last_aid = n;
        doz      = 1'b1;
      end
    end
    n1 = doz ? ((first_aid >> 3) & ~1) : 0;
    n2 = doz ? (last_aid >> 3) : 0;
  endfunction

  function automatic res_t single_result(status_e st);
    res_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic void predict_tim(req_t r);
    int   n1;
    int   n2;
    int   len;
    int   done;
    int   cnt;
    bit   doz;
    res_t res;
    case (op_e'(r.op))
      OP_SET: begin
        if (r.aid >= AidCount) begin
          pending_results.push_back(single_result(STATUS_BAD_AID));
          bad_aids++;
        end else begin
          tim_bits[r.aid >> 3][r.aid[2:0]] = r.has_traffic;
          pending_results.push_back(single_result(STATUS_OK));
        end
      end
      OP_CLEAR: begin
        foreach (tim_bits[i]) tim_bits[i] = '0;
        pending_results.push_back(single_result(STATUS_OK));
      end
      OP_READ: begin
        find_span(n1, n2, doz);
        len                = n2 - n1 + 1;
        res                = '0;
        res.bitmap_length  = len[7:0];
        res.group_traffic  = tim_bits[0][0];
        res.dozing_clients = doz;
        reads_sent++;
        if (r.buffer_len < len) begin
          res.status = STATUS_NO_ROOM;
          res.last   = 1'b1;
          pending_results.push_back(res);
          reads_no_room++;
        end else begin
          res.status     = STATUS_OK;
          res.pvb_offset = 7'(n1 >> 1);
          done = 0;
          while (done < len) begin
            res.data_word = '0;
            cnt = 0;
            while (cnt < 8 && done < len) begin
              res.data_word[8*cnt +: 8] = tim_bits[n1 + done];
              cnt++;
              done++;
            end
            res.data_bytes = 4'(cnt);
            res.last       = (done >= len);
            pending_results.push_back(res);
          end
        end
      end
      default: begin
        pending_results.push_back(single_result(STATUS_OK));
      end
    endcase
  endfunction

  function automatic string fmt_result(res_t r);
    return $sformatf("st=%0d off=%0d len=%0d grp=%b doz=%b word=%h bytes=%0d last=%b",
                     r.status, r.pvb_offset, r.bitmap_length, r.group_traffic,
                     r.dozing_clients, r.data_word, r.data_bytes, r.last);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReport) $display("%0t: %s", $time, msg);
  endfunction

  // start_i stays high after acceptance; the next request or a gap decides
  task automatic send_request(req_t r);
    req_i   <= r;
    start_i <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (busy_o);
    predict_tim(r);
  endtask

  task automatic sender_gap();
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 40 : 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic req_t random_request(int center, int span);
    req_t r;
    int   pick;
    int   n1;
    int   n2;
    int   len;
    bit   doz;
    r.op          = OP_SET;
    r.aid         = 12'($urandom_range(4095));
    r.has_traffic = ($urandom_range(3) != 0);
    r.buffer_len  = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 50) begin
      case ($urandom_range(11))
        0:       r.aid = 12'($urandom_range(AidCount, 4095));
        1:       r.aid = 12'($urandom_range(1) ? 0 : AidCount - 1);
        default: r.aid = 12'(center + $urandom_range(span));
      endcase
    end else if (pick < 85) begin
      r.op = OP_READ;
      if ($urandom_range(2) != 0) begin
        // aim the buffer length at the boundary of what the read needs
        find_span(n1, n2, doz);
        len = n2 - n1 + 1;
        case ($urandom_range(3))
          0:       len = len - 1;
          1:       len = len;
          2:       len = len + $urandom_range(3);
          default: len = 255;
        endcase
        if (len > 255) len = 255;
        r.buffer_len = 8'(len);
      end
    end else if (pick < 93) begin
      r.op = OP_CLEAR;
    end else if (pick < 97) begin
      r.op = OP_NONE;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : check_results
    res_t  want;
    string diffs;
    if (rst_ni && res_valid_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: got %s", fmt_result(res_o)));
      end else begin
        want  = pending_results.pop_front();
        diffs = "";
        if (res_o.status !== want.status) diffs = {diffs, " status"};
        if (res_o.pvb_offset !== want.pvb_offset) diffs = {diffs, " offset"};
        if (res_o.bitmap_length !== want.bitmap_length) diffs = {diffs, " length"};
        if (res_o.group_traffic !== want.group_traffic) diffs = {diffs, " group"};
        if (res_o.dozing_clients !== want.dozing_clients) diffs = {diffs, " dozing"};
        if (res_o.data_word !== want.data_word) diffs = {diffs, " word"};
        if (res_o.data_bytes !== want.data_bytes) diffs = {diffs, " bytes"};
        if (res_o.last !== want.last) diffs = {diffs, " last"};
        if (diffs != "") begin
          note_mismatch($sformatf("bad field(s)%s: expected %s, got %s",
                                  diffs, fmt_result(want), fmt_result(res_o)));
        end
      end
    end
  end

  task automatic test_directed();
    idle_pct = 0;
    send_request(make_request(OP_READ, 0, 0, 0));       // empty map, no room for one byte
    send_request(make_request(OP_READ, 4095, 1, 1));    // empty map, one zero byte
    send_request(make_request(OP_NONE, 4095, 1, 255));  // unused op code
    send_request(make_request(OP_SET, 0, 1, 0));
    send_request(make_request(OP_READ, 0, 0, 1));       // only group bit set
    send_request(make_request(OP_SET, 1, 1, 0));
    send_request(make_request(OP_SET, AidCount - 1, 1, 0));
    send_request(make_request(OP_READ, 0, 0, 255));     // full-span read
    send_request(make_request(OP_READ, 0, 0, 250));     // one byte short
    send_request(make_request(OP_SET, AidCount, 1, 0)); // first invalid AID
    send_request(make_request(OP_SET, 4095, 0, 0));
    send_request(make_request(OP_SET, AidCount - 1, 0, 0));
    send_request(make_request(OP_SET, 1, 0, 0));
    send_request(make_request(OP_SET, 17, 1, 0));
    send_request(make_request(OP_SET, 40, 1, 0));
    send_request(make_request(OP_READ, 0, 0, 4));       // exact fit, N1 already even
    send_request(make_request(OP_READ, 0, 0, 3));
    send_request(make_request(OP_CLEAR, 4095, 1, 255));
    send_request(make_request(OP_READ, 0, 0, 255));
    send_request(make_request(OP_SET, 1000, 1, 0));
    send_request(make_request(OP_READ, 0, 0, 8));
    drain_results();
  endtask

  task automatic test_random(int pct, int count);
    int center;
    int span;
    idle_pct = pct;
    span     = 1;
    center   = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        span   = ($urandom_range(4) == 0) ? $urandom_range(200, AidCount - 1)
                                          : $urandom_range(1, 60);
        center = $urandom_range(AidCount - 1 - span);
      end
      sender_gap();
      send_request(random_request(center, span));
    end
    // let everything come back before the next phase
    drain_results();
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    req_i          = '0;
    idle_pct       = 0;
    mismatch_count = 0;
    results_seen   = 0;
    reads_sent     = 0;
    reads_no_room  = 0;
    bad_aids       = 0;
    foreach (tim_bits[i]) tim_bits[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(0, 80);
    test_random(64, 80);
    test_random(29, 80);
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d reads (%0d refused for buffer size) and %0d invalid AIDs,",
             reads_sent, reads_no_room, bad_aids);
    $display("with %0d results checked across idle rates of 0, 64 and 29 percent.",
             results_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d results still pending", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
